>>> hw/rtl/wfc_pkg.sv
package wfc_pkg;

  localparam int TABLE_ENTRIES  = 1024;
  localparam int MAX_WORD_CHARS = 59;

  localparam int IDX_W      = $clog2(TABLE_ENTRIES);
  localparam int USED_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int LEN_W      = $clog2(MAX_WORD_CHARS + 1);
  localparam int POS_W      = (MAX_WORD_CHARS > 1) ? $clog2(MAX_WORD_CHARS) : 1;
  localparam int CHAR_DEPTH = TABLE_ENTRIES * MAX_WORD_CHARS;
  localparam int CADDR_W    = $clog2(CHAR_DEPTH);
  localparam int COUNT_W    = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(MAX_WORD_CHARS - 1);

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_word;
  } request_t;

  typedef struct packed {
    logic [9:0]         entry_index;
    logic [COUNT_W-1:0] word_count;
    logic               was_new;
    logic               table_full;
    logic               was_truncated;
  } result_t;

endpackage

>>> hw/rtl/wfc_ram.sv
module wfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/wfc_cell.sv
module wfc_cell
  import wfc_pkg::*;
(
  input  logic       clk,
  input  logic       load_en,
  input  logic [7:0] load_data,
  input  logic       shift_en,
  input  logic [7:0] shift_in,
  output logic [7:0] value
);

  // hold one pending byte; load from the request or take the neighbor's byte
  always_ff @(posedge clk) begin
    if (load_en) begin
      value <= load_data;
    end else if (shift_en) begin
      value <= shift_in;
    end
  end

endmodule

>>> hw/rtl/word_frequency_counter.sv
// Word frequency counter.
// Requests carry one byte of a word (char_code) and a last-byte flag
// (end_of_word); a request is taken on a rising edge with start high and
// busy low. A byte that is not the last gives no result.
// Every byte past the maximum word length is dropped and the word flagged.
// At a word end the block walks the stored entries in order. Each entry
// has its stored length read and checked, and only when the length matches
// are the bytes compared, through the single read port of the byte RAM
// and the ring of pending-byte cells that rotates one byte per cycle.
// A match ends the walk and updates the count (saturating).
// With no match the word is appended byte by byte into a new entry, or
// dropped with table_full when the table is full.
// The result is shown on result for exactly one cycle with done high; the
// receiver cannot stall, and busy is low again in that same cycle.
// Reset clears the entry count, the pending length and the overflow flag;
// the stores need no clearing since only written entries are read.
module word_frequency_counter
  import wfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_LEN  = 3'd1;
  localparam logic [2:0] S_CMP_LEN = 3'd2;
  localparam logic [2:0] S_CMP     = 3'd3;
  localparam logic [2:0] S_CMP_END = 3'd4;
  localparam logic [2:0] S_UPD     = 3'd5;
  localparam logic [2:0] S_NEXT    = 3'd6;
  localparam logic [2:0] S_INSERT  = 3'd7;
  localparam logic [2:0] S_COPY    = 3'd0;

  logic [2:0]         state;
  logic               copying;
  logic [USED_W-1:0]  used;
  logic [LEN_W-1:0]   plen;
  logic               ovf;
  logic [IDX_W-1:0]   e;
  logic [CADDR_W-1:0] base;
  logic [POS_W-1:0]   pos;
  logic               match;
  logic               cmpv;
  logic [7:0]         head_d;

  logic               accept;
  logic               shift_en;
  logic [7:0]         cells [MAX_WORD_CHARS];

  logic               len_we;
  logic [LEN_W-1:0]   len_q;
  logic               cnt_we;
  logic [COUNT_W-1:0] cnt_wd;
  logic [COUNT_W-1:0] cnt_q;
  logic               chr_we;
  logic [CADDR_W-1:0] chr_addr;
  logic [7:0]         chr_q;
  logic               cur_ok;
  logic               in_word;

  assign busy     = (state != S_IDLE) || copying;
  assign accept   = start && !busy;
  assign shift_en = (state == S_CMP) || copying;
  assign chr_addr = base + CADDR_W'(pos);
  assign in_word  = {1'b0, pos} < (LEN_W + 1)'(plen);
  assign cur_ok   = !(cmpv && (chr_q != head_d));

  // ring of pending-byte cells; cell 0 presents the byte under compare
  for (genvar k = 0; k < MAX_WORD_CHARS; k++) begin : g_cell
    wfc_cell u_cell (
      .clk      (clk),
      .load_en  (accept && (plen == LEN_W'(k))),
      .load_data(request.char_code),
      .shift_en (shift_en),
      .shift_in (cells[(k + 1) % MAX_WORD_CHARS]),
      .value    (cells[k])
    );
  end

  wfc_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_ENTRIES)) u_len_ram (
    .clk    (clk),
    .wr_en  (len_we),
    .wr_addr(used[IDX_W-1:0]),
    .wr_data(plen),
    .rd_addr(e),
    .rd_data(len_q)
  );

  wfc_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk    (clk),
    .wr_en  (cnt_we),
    .wr_addr(len_we ? used[IDX_W-1:0] : e),
    .wr_data(cnt_wd),
    .rd_addr(e),
    .rd_data(cnt_q)
  );

  wfc_ram #(.WIDTH(8), .DEPTH(CHAR_DEPTH)) u_chr_ram (
    .clk    (clk),
    .wr_en  (chr_we),
    .wr_addr(chr_addr),
    .wr_data(cells[0]),
    .rd_addr(chr_addr),
    .rd_data(chr_q)
  );

  always_comb begin
    len_we = 1'b0;
    cnt_we = 1'b0;
    cnt_wd = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
    chr_we = copying && in_word;
    if (state == S_UPD) begin
      cnt_we = 1'b1;
    end else if ((state == S_INSERT) && (used != USED_W'(TABLE_ENTRIES))) begin
      len_we = 1'b1;
      cnt_we = 1'b1;
      cnt_wd = COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      copying <= 1'b0;
      used    <= '0;
      plen    <= '0;
      ovf     <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (copying) begin
        // write the pending word into its new entry, one byte a cycle
        pos <= pos + 1'b1;
        if (pos == LAST_POS) begin
          copying              <= 1'b0;
          done                 <= 1'b1;
          result.entry_index   <= 10'(used);
          result.word_count    <= COUNT_W'(1);
          result.was_new       <= 1'b1;
          result.table_full    <= 1'b0;
          result.was_truncated <= ovf;
          used                 <= used + 1'b1;
          plen                 <= '0;
          ovf                  <= 1'b0;
        end
      end else begin
        unique case (state)
          S_IDLE: begin
            if (accept) begin
              if (plen != LEN_W'(MAX_WORD_CHARS)) begin
                plen <= plen + 1'b1;
              end else begin
                ovf <= 1'b1;
              end
              if (request.end_of_word) begin
                e    <= '0;
                base <= '0;
                state <= (used == '0) ? S_INSERT : S_RD_LEN;
              end
            end
          end
          S_RD_LEN: begin
            state <= S_CMP_LEN;
          end
          S_CMP_LEN: begin
            pos   <= '0;
            match <= 1'b1;
            cmpv  <= 1'b0;
            state <= (len_q == plen) ? S_CMP : S_NEXT;
          end
          S_CMP: begin
            // advance the ring; compare the byte read for the previous slot
            head_d <= cells[0];
            cmpv   <= in_word;
            match  <= match && cur_ok;
            pos    <= pos + 1'b1;
            if (pos == LAST_POS) begin
              state <= S_CMP_END;
            end
          end
          S_CMP_END: begin
            state <= (match && cur_ok) ? S_UPD : S_NEXT;
          end
          S_UPD: begin
            done                 <= 1'b1;
            result.entry_index   <= 10'(e);
            result.word_count    <= cnt_wd;
            result.was_new       <= 1'b0;
            result.table_full    <= 1'b0;
            result.was_truncated <= ovf;
            plen                 <= '0;
            ovf                  <= 1'b0;
            state                <= S_IDLE;
          end
          S_NEXT: begin
            e    <= e + 1'b1;
            base <= base + CADDR_W'(MAX_WORD_CHARS);
            state <= (USED_W'(e) + 1'b1 == used) ? S_INSERT : S_RD_LEN;
          end
          S_INSERT: begin
            pos <= '0;
            if (used == USED_W'(TABLE_ENTRIES)) begin
              // drop the word: no room left
              done                 <= 1'b1;
              result.entry_index   <= '0;
              result.word_count    <= '0;
              result.was_new       <= 1'b0;
              result.table_full    <= 1'b1;
              result.was_truncated <= ovf;
              plen                 <= '0;
              ovf                  <= 1'b0;
              state                <= S_IDLE;
            end else begin
              copying <= 1'b1;
              state   <= S_COPY;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // a result always hands control back to the request side
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  // pending length never runs past the word limit
  assert property (@(posedge clk) disable iff (rst) plen <= LEN_W'(MAX_WORD_CHARS))
    else $error("pending length overflow");

  // entry count never exceeds the table size
  assert property (@(posedge clk) disable iff (rst) used <= USED_W'(TABLE_ENTRIES))
    else $error("entry count overflow");

  // a new entry is only reported after the table had room
  assert property (@(posedge clk) disable iff (rst)
    (done && result.was_new) |-> !result.table_full)
    else $error("new entry flagged with full table");

endmodule

>>> tb/tb_word_frequency_counter.sv
`timescale 1ns / 1ps

module tb_word_frequency_counter;
  import wfc_pkg::*;

  typedef logic [7:0] word_bytes_t[$];

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;

  word_frequency_counter uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  // Clock: 8 ns period.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Pending requests, filled up front by the stimulus block.
  request_t char_queue[$];
  // Word-end results still owed by the block, oldest first.
  result_t  tally_queue[$];

  int  fail_count;
  int  sent_count;

  // Our own copy of the word table.
  logic [7:0]         table_chars[TABLE_ENTRIES][MAX_WORD_CHARS];
  int                 table_lens[TABLE_ENTRIES];
  logic [COUNT_W-1:0] table_counts[TABLE_ENTRIES];
  int                 table_used;
  logic [7:0]         word_chars[MAX_WORD_CHARS];
  int                 word_len;
  bit                 word_overflow;

  // Fold one accepted request into the table copy; at a word end, queue the
  // result the block owes for it.
  task automatic tally_char(input request_t r);
    result_t exp_res;
    bit      hit;
    bit      same;
    if (word_len < MAX_WORD_CHARS) begin
      word_chars[word_len] = r.char_code;
      word_len++;
    end else begin
      word_overflow = 1'b1;
    end
    if (!r.end_of_word) return;
    exp_res = '0;
    hit = 1'b0;
    for (int e = 0; e < table_used && !hit; e++) begin
      same = (table_lens[e] == word_len);
      for (int i = 0; i < word_len && same; i++)
        if (table_chars[e][i] != word_chars[i]) same = 1'b0;
      if (same) begin
        hit = 1'b1;
        // Saturate the count at all ones.
        if (table_counts[e] != COUNT_MAX) table_counts[e]++;
        exp_res.entry_index = e[9:0];
        exp_res.word_count  = table_counts[e];
      end
    end
    if (!hit) begin
      if (table_used < TABLE_ENTRIES) begin
        for (int i = 0; i < word_len; i++) table_chars[table_used][i] = word_chars[i];
        table_lens[table_used]   = word_len;
        table_counts[table_used] = 1;
        exp_res.entry_index = table_used[9:0];
        exp_res.word_count  = 1;
        exp_res.was_new     = 1'b1;
        table_used++;
      end else begin
        // Table full: drop the word, report index and count as zero.
        exp_res.table_full = 1'b1;
      end
    end
    exp_res.was_truncated = word_overflow;
    tally_queue.push_back(exp_res);
    word_len = 0;
    word_overflow = 1'b0;
  endtask

  // Split a word into byte requests, last byte flagged.
  task automatic queue_word(input word_bytes_t w);
    request_t r;
    foreach (w[i]) begin
      r.char_code   = w[i];
      r.end_of_word = (i == w.size() - 1);
      char_queue.push_back(r);
    end
  endtask

  function automatic word_bytes_t random_word(input int len);
    word_bytes_t w;
    for (int i = 0; i < len; i++) w.push_back(8'($urandom_range(0, 255)));
    return w;
  endfunction

  // Driver: hold a request until taken, idle now and then except in a stretch
  // in the middle of the run (sent counts 300 to 700) where it never idles.
  always @(posedge clk) begin
    bit taken;
    bit idle;
    if (rst) begin
      start   <= 1'b0;
      request <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        tally_char(request);
        sent_count++;
      end
      if (!start || taken) begin
        idle = (sent_count < 300 || sent_count > 700) && ($urandom_range(0, 99) < 12);
        if (char_queue.size() != 0 && !idle) begin
          start   <= 1'b1;
          request <= char_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result must match the oldest owed result.
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && done) begin
      if (tally_queue.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        fail_count++;
      end else begin
        exp_res = tally_queue.pop_front();
        if (result.entry_index !== exp_res.entry_index) begin
          $display("%0t: entry_index expected %0d actual %0d", $time,
                   exp_res.entry_index, result.entry_index);
          fail_count++;
        end
        if (result.word_count !== exp_res.word_count) begin
          $display("%0t: word_count expected %0d actual %0d", $time,
                   exp_res.word_count, result.word_count);
          fail_count++;
        end
        if (result.was_new !== exp_res.was_new) begin
          $display("%0t: was_new expected %0b actual %0b", $time,
                   exp_res.was_new, result.was_new);
          fail_count++;
        end
        if (result.table_full !== exp_res.table_full) begin
          $display("%0t: table_full expected %0b actual %0b", $time,
                   exp_res.table_full, result.table_full);
          fail_count++;
        end
        if (result.was_truncated !== exp_res.was_truncated) begin
          $display("%0t: was_truncated expected %0b actual %0b", $time,
                   exp_res.was_truncated, result.was_truncated);
          fail_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    word_bytes_t w;
    word_bytes_t vocab[$];
    int          items;
    int          pick;
    fail_count    = 0;
    sent_count    = 0;
    table_used    = 0;
    word_len      = 0;
    word_overflow = 1'b0;
    rst           = 1'b1;
    start         = 1'b0;
    request       = '0;

    // Directed: byte zero, byte extremes, repeats, prefixes, exact and
    // overlong lengths.
    w = {8'h00};                     queue_word(w);
    w = {8'hFF};                     queue_word(w);
    w = {8'h00};                     queue_word(w);
    w = {8'h55, 8'hAA};              queue_word(w);
    w = {8'h55, 8'hAA, 8'h00};       queue_word(w);
    w = {8'h55};                     queue_word(w);
    w = {8'hAA, 8'h55};              queue_word(w);
    w = {8'h55, 8'hAA};              queue_word(w);
    w = random_word(MAX_WORD_CHARS); queue_word(w);
    queue_word(w);
    // One byte past the limit, then three bytes past it: both fold onto the same entry.
    w.push_back(8'h01);              queue_word(w);
    w.push_back(8'hFE);
    w.push_back(8'h80);              queue_word(w);
    w = random_word(MAX_WORD_CHARS + 1); queue_word(w);

    // Random: mostly a small vocabulary so counts climb, some fresh words,
    // a few long and overlong ones.
    for (int i = 0; i < 40; i++) vocab.push_back(random_word($urandom_range(1, 6)));
    items = char_queue.size();
    while (items < 900) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) w = vocab[$urandom_range(0, vocab.size() - 1)];
      else if (pick < 90) w = random_word($urandom_range(1, 8));
      else if (pick < 95) w = random_word($urandom_range(MAX_WORD_CHARS - 2, MAX_WORD_CHARS));
      else w = random_word($urandom_range(MAX_WORD_CHARS + 1, MAX_WORD_CHARS + 8));
      queue_word(w);
      items += w.size();
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain: all requests taken, all results seen, then a short settle.
    wait (char_queue.size() == 0 && !start && tally_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && tally_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: even every word walking a few hundred same-length entries
  // stays well below this.
  initial begin
    #1_000_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/wfc_pkg.sv
hw/rtl/wfc_ram.sv
hw/rtl/wfc_cell.sv
hw/rtl/word_frequency_counter.sv
tb/tb_word_frequency_counter.sv
